// ----- hdl/fwr_pkg.sv -----
// ----------------------------------------------------------------------------
// fwr_pkg: shared types and functions of the framed word receiver
// Status codes, the entry that travels from the front end to the back end,
// and the CRC-16 byte fold.
// ----------------------------------------------------------------------------
package fwr_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [WORD_W-1:0] CRC_TOP  = 16'h8000;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_VALID      = 2'd1,
        ST_MISMATCH   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_INCOMPLETE = 1'b0,
        KIND_CHECK      = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        POS_LOW  = 2'd0,
        POS_HIGH = 2'd1,
        POS_SUM1 = 2'd2,
        POS_SUM0 = 2'd3
    } pos_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
        logic [WORD_W-1:0]  crc_hi;
        logic [WORD_W-1:0]  rx;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] crc;
        crc = crc_in ^ {b, {(WORD_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if ((crc & CRC_TOP) != '0)
            begin
                crc = {crc[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[WORD_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- hdl/fwr_front.sv -----
// ----------------------------------------------------------------------------
// fwr_front: byte capture and frame classification
// Counts bytes within a frame, stores the data bytes and the first checksum
// byte and folds the high byte into the CRC as soon as it arrives.
// ----------------------------------------------------------------------------
module fwr_front
    import fwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] bus_byte,
    input  q_status_t         q_status,
    output logic              push,
    output entry_t            push_entry
);

    pos_t              pos_reg, pos_next;
    logic [BYTE_W-1:0] lo_reg, lo_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;
    logic [BYTE_W-1:0] sum1_reg, sum1_next;
    logic [WORD_W-1:0] crc_hi_reg, crc_hi_next;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        pos_next    = pos_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sum1_next   = sum1_reg;
        crc_hi_next = crc_hi_reg;
        push_entry  = '{kind: KIND_INCOMPLETE, lo: lo_reg, hi: hi_reg,
                        crc_hi: crc_hi_reg, rx: {sum1_reg, bus_byte}};
        unique case (pos_reg)
            POS_LOW:
            begin
                lo_next  = bus_byte;
                pos_next = POS_HIGH;
            end
            POS_HIGH:
            begin
                hi_next     = bus_byte;
                crc_hi_next = crc_fold('0, bus_byte);
                pos_next    = POS_SUM1;
            end
            POS_SUM1:
            begin
                sum1_next = bus_byte;
                pos_next  = POS_SUM0;
            end
            POS_SUM0:
            begin
                push_entry.kind = KIND_CHECK;
                pos_next        = POS_LOW;
            end
            default:
            begin
                pos_next = POS_LOW;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_LOW;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            sum1_reg   <= sum1_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

// ----- hdl/fwr_queue.sv -----
// ----------------------------------------------------------------------------
// fwr_queue: short queue between the front end and the back end
// A small register FIFO that lets each side stall independently.
// ----------------------------------------------------------------------------
module fwr_queue
    import fwr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    pop_entry,
    output q_status_t q_status
);

    entry_t            store [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_pop         = pop && !q_status.empty;
    assign pop_entry      = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/fwr_back.sv -----
// ----------------------------------------------------------------------------
// fwr_back: checksum comparison and result register
// Folds the low byte into the CRC, compares it with the received checksum
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module fwr_back
    import fwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  entry_t            pop_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] data_word
);

    logic              valid_reg;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] crc;

    assign pop       = !q_status.empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign data_word = word_reg;
    assign crc       = crc_fold(pop_entry.crc_hi, pop_entry.lo);

    always_comb
    begin
        status_next = ST_INCOMPLETE;
        word_next   = '0;
        unique case (pop_entry.kind)
            KIND_INCOMPLETE:
            begin
                status_next = ST_INCOMPLETE;
            end
            KIND_CHECK:
            begin
                if (crc == pop_entry.rx)
                begin
                    status_next = ST_VALID;
                    word_next   = {pop_entry.hi, pop_entry.lo};
                end
                else
                begin
                    status_next = ST_MISMATCH;
                end
            end
            default:
            begin
                status_next = ST_INCOMPLETE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            word_reg   <= word_next;
        end
    end

endmodule

// ----- hdl/framed_word_receiver_crc16.sv -----
// ----------------------------------------------------------------------------
// framed_word_receiver_crc16: four-byte framed word receiver with CRC-16 check
// Groups bus bytes into frames of low byte, high byte and a big-endian
// CRC-16 (polynomial 0x1021, initial value zero) and reports each word.
// ----------------------------------------------------------------------------
// Usage: one byte enters per input beat on bus_byte (in_valid, in_stall).
// Every input beat produces exactly one output beat (out_valid, out_stall)
// carrying status and data_word. The first three bytes of a frame report
// an incomplete frame; the fourth reports the word, or a checksum mismatch
// with a zero word, and the next byte starts a new frame.
// The input beat is stored in the queue and its output beat is then
// registered. The block takes one byte per cycle while in_stall is low:
// the CRC of the high byte is folded in when that byte arrives and the low
// byte is folded in by the back end in the cycle its result is registered.
// A two-entry queue separates capture from the result register, so input
// continues to be taken while a result waits. When the receiver stalls,
// the result holds and in_stall rises once the queue is full.
// Reset clears the byte position, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module framed_word_receiver_crc16
    import fwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] bus_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] data_word
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    entry_t    push_entry;
    entry_t    pop_entry;

    fwr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .bus_byte   (bus_byte),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    fwr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    fwr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_word (data_word)
    );

endmodule

// ----- hdl/fwr_checker.sv -----
// ----------------------------------------------------------------------------
// fwr_checker: port-level checks of the framed word receiver
// Watches the top-level ports for result hold, legal status codes, zero
// words on incomplete or failed frames, input stall without a result and valid after reset.
// ----------------------------------------------------------------------------
module fwr_checker
    import fwr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [WORD_W-1:0] data_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_word))
        else $error("output beat changed while stalled");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_INCOMPLETE || status == ST_VALID
                       || status == ST_MISMATCH))
        else $error("illegal status code");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_VALID |-> data_word == '0)
        else $error("non-zero word without a valid frame");

    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result beat waiting");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind framed_word_receiver_crc16 fwr_checker u_fwr_checker (.*);
